### rtl/l2mlf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// l2mlf_pkg
// Shared types and constants for the MAC learning forwarder.
// ----------------------------------------------------------------------------
package l2mlf_pkg;

  localparam int unsigned MAC_W     = 48;
  localparam int unsigned ACTION_W  = 2;
  localparam int unsigned MASK_W    = 8;
  localparam int unsigned OPORT_W   = 3;
  localparam int unsigned INPORT_W  = 3;
  localparam int unsigned LIMIT_W   = 7;
  localparam int unsigned AGECFG_W  = 32;
  localparam int unsigned PORTCFG_W = 4;
  localparam logic [AGECFG_W-1:0] AGING_DEFAULT = 32'd10;

  typedef enum logic [ACTION_W-1:0] {
    ACT_UNICAST = 2'd0,
    ACT_BCAST   = 2'd1,
    ACT_UNKNOWN = 2'd2,
    ACT_DISCARD = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    REG_LIMIT = 2'd0,
    REG_AGING = 2'd1,
    REG_PORTS = 2'd2
  } reg_idx_t;

  // Commands broadcast to every cell.
  typedef enum logic [2:0] {
    CMD_NONE   = 3'd0,
    CMD_LOOKUP = 3'd1,
    CMD_REFR   = 3'd2,
    CMD_PURGE  = 3'd3,
    CMD_DROP   = 3'd4,
    CMD_INSERT = 3'd5
  } cmd_t;

endpackage
`default_nettype wire

### rtl/l2mlf_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// l2mlf_cell
// One table entry: match compare, age, and a stage of the oldest-entry and
// first-free chains that run through the row.
// ----------------------------------------------------------------------------
module l2mlf_cell #(
  parameter int unsigned TW  = 32,
  parameter int unsigned IDW = 6
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire l2mlf_pkg::cmd_t        cmd,
  input  wire [l2mlf_pkg::MAC_W-1:0]  key_mac,
  input  wire [2:0]                   key_port,
  input  wire [TW-1:0]                key_now,
  input  wire [TW-1:0]                aging_lim,
  input  wire                         sel,
  input  wire [IDW-1:0]               my_id,
  // chain in
  input  wire                         c_found_i,
  input  wire [TW-1:0]                c_age_i,
  input  wire [l2mlf_pkg::MAC_W-1:0]  c_mac_i,
  input  wire [IDW-1:0]               c_id_i,
  input  wire                         c_free_i,
  input  wire [IDW-1:0]               c_free_id_i,
  // chain out
  output logic                        c_found_o,
  output logic [TW-1:0]               c_age_o,
  output logic [l2mlf_pkg::MAC_W-1:0] c_mac_o,
  output logic [IDW-1:0]              c_id_o,
  output logic                        c_free_o,
  output logic [IDW-1:0]              c_free_id_o,
  output logic                        valid_o,
  output logic                        hit_o,
  output logic                        aged_o,
  output logic [2:0]                  port_o
);

  logic                        valid_r;
  logic [l2mlf_pkg::MAC_W-1:0] mac_r;
  logic [2:0]                  port_r;
  logic [TW-1:0]               time_r;
  logic [TW-1:0]               age;
  logic                        better;

  assign age     = key_now - time_r;
  assign aged_o  = age >= aging_lim;
  assign hit_o   = valid_r && (mac_r == key_mac);
  assign valid_o = valid_r;
  assign port_o  = port_r;

  assign better = valid_r && (!c_found_i || age > c_age_i ||
                  (age == c_age_i && mac_r < c_mac_i));

  always_comb begin
    c_found_o   = c_found_i | valid_r;
    c_age_o     = better ? age : c_age_i;
    c_mac_o     = better ? mac_r : c_mac_i;
    c_id_o      = better ? my_id : c_id_i;
    c_free_o    = c_free_i | !valid_r;
    c_free_id_o = (!c_free_i && !valid_r) ? my_id : c_free_id_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      unique case (cmd)
        l2mlf_pkg::CMD_PURGE:  if (valid_r && aged_o) valid_r <= 1'b0;
        l2mlf_pkg::CMD_DROP:   if (sel) valid_r <= 1'b0;
        l2mlf_pkg::CMD_INSERT: if (sel) valid_r <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((cmd == l2mlf_pkg::CMD_INSERT || cmd == l2mlf_pkg::CMD_REFR) && sel) begin
      mac_r  <= key_mac;
      port_r <= key_port;
      time_r <= key_now;
    end
  end

endmodule
`default_nettype wire

### rtl/l2mlf_row.sv
`default_nettype none
// ----------------------------------------------------------------------------
// l2mlf_row
// Row of entry cells; the oldest and free chains are registered after every
// SEG cells but the last, so a scan settles through those registers.
// ----------------------------------------------------------------------------
module l2mlf_row #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned TW    = 32,
  parameter int unsigned SEG   = 8
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire l2mlf_pkg::cmd_t             cmd,
  input  wire [l2mlf_pkg::MAC_W-1:0]       key_mac,
  input  wire [2:0]                        key_port,
  input  wire [TW-1:0]                     key_now,
  input  wire [TW-1:0]                     aging_lim,
  input  wire [$clog2(DEPTH)-1:0]          sel_id,
  output logic                             hit,
  output logic [$clog2(DEPTH)-1:0]         hit_id,
  output logic                             hit_aged,
  output logic [2:0]                       hit_port,
  output logic [$clog2(DEPTH+1)-1:0]       aged_cnt,
  output logic                             old_found,
  output logic [$clog2(DEPTH)-1:0]         old_id,
  output logic                             free_found,
  output logic [$clog2(DEPTH)-1:0]         free_id
);

  localparam int unsigned IDW = $clog2(DEPTH);
  localparam int unsigned CW  = $clog2(DEPTH+1);

  logic                        f_i   [DEPTH+1];
  logic [TW-1:0]               a_i   [DEPTH+1];
  logic [l2mlf_pkg::MAC_W-1:0] m_i   [DEPTH+1];
  logic [IDW-1:0]              d_i   [DEPTH+1];
  logic                        fr_i  [DEPTH+1];
  logic [IDW-1:0]              fd_i  [DEPTH+1];
  logic                        f_o   [DEPTH];
  logic [TW-1:0]               a_o   [DEPTH];
  logic [l2mlf_pkg::MAC_W-1:0] m_o   [DEPTH];
  logic [IDW-1:0]              d_o   [DEPTH];
  logic                        fr_o  [DEPTH];
  logic [IDW-1:0]              fd_o  [DEPTH];
  logic [DEPTH-1:0]            v_vec, h_vec, ag_vec;
  logic [2:0]                  p_arr [DEPTH];

  assign f_i[0]  = 1'b0;
  assign a_i[0]  = '0;
  assign m_i[0]  = '0;
  assign d_i[0]  = '0;
  assign fr_i[0] = 1'b0;
  assign fd_i[0] = '0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    l2mlf_cell #(.TW(TW), .IDW(IDW)) u_cell (
      .clk, .rst_n, .cmd, .key_mac, .key_port, .key_now, .aging_lim,
      .sel(sel_id == IDW'(g)), .my_id(IDW'(g)),
      .c_found_i(f_i[g]), .c_age_i(a_i[g]), .c_mac_i(m_i[g]), .c_id_i(d_i[g]),
      .c_free_i(fr_i[g]), .c_free_id_i(fd_i[g]),
      .c_found_o(f_o[g]), .c_age_o(a_o[g]), .c_mac_o(m_o[g]), .c_id_o(d_o[g]),
      .c_free_o(fr_o[g]), .c_free_id_o(fd_o[g]),
      .valid_o(v_vec[g]), .hit_o(h_vec[g]), .aged_o(ag_vec[g]), .port_o(p_arr[g])
    );
    if (((g + 1) % SEG) == 0 && g != DEPTH - 1) begin : g_reg
      logic                        f_r, fr_r;
      logic [TW-1:0]               a_r;
      logic [l2mlf_pkg::MAC_W-1:0] m_r;
      logic [IDW-1:0]              d_r, fd_r;
      always_ff @(posedge clk) begin
        f_r  <= f_o[g];
        a_r  <= a_o[g];
        m_r  <= m_o[g];
        d_r  <= d_o[g];
        fr_r <= fr_o[g];
        fd_r <= fd_o[g];
      end
      assign f_i[g+1]  = f_r;
      assign a_i[g+1]  = a_r;
      assign m_i[g+1]  = m_r;
      assign d_i[g+1]  = d_r;
      assign fr_i[g+1] = fr_r;
      assign fd_i[g+1] = fd_r;
    end else begin : g_wire
      assign f_i[g+1]  = f_o[g];
      assign a_i[g+1]  = a_o[g];
      assign m_i[g+1]  = m_o[g];
      assign d_i[g+1]  = d_o[g];
      assign fr_i[g+1] = fr_o[g];
      assign fd_i[g+1] = fd_o[g];
    end
  end

  assign old_found  = f_i[DEPTH];
  assign old_id     = d_i[DEPTH];
  assign free_found = fr_i[DEPTH];
  assign free_id    = fd_i[DEPTH];

  always_comb begin
    hit      = 1'b0;
    hit_id   = '0;
    aged_cnt = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (h_vec[i]) begin
        hit    = 1'b1;
        hit_id = IDW'(i);
      end
      aged_cnt = aged_cnt + CW'(v_vec[i] & ag_vec[i]);
    end
    hit_aged = ag_vec[hit_id];
    hit_port = p_arr[hit_id];
  end

endmodule
`default_nettype wire

### rtl/l2_mac_learning_forwarder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// l2_mac_learning_forwarder
// Layer-2 bridge lookup with MAC learning and aging.
// ----------------------------------------------------------------------------
// One header at a time. With a known source the header passes the source
// lookup and refresh, destination, resolve and output states, and then the
// block is idle for the next header. A new source adds a free-slot scan whose
// length is set by the registered segments of the cell row, plus a check and
// an insert state. Into a full table a purge state comes first, and each
// eviction adds a drop, a fresh scan and a check. The result sits in an
// output register; the next header is taken while it waits and is held
// before resolution until that result is accepted.
module l2_mac_learning_forwarder #(
  parameter int unsigned NUM_PORTS   = 8,
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned TIME_WIDTH  = 32
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire [l2mlf_pkg::MAC_W-1:0]        in_src_mac,
  input  wire [l2mlf_pkg::MAC_W-1:0]        in_dest_mac,
  input  wire [l2mlf_pkg::INPORT_W-1:0]     in_in_port,
  input  wire [TIME_WIDTH-1:0]              in_now,
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic [l2mlf_pkg::ACTION_W-1:0]    out_action,
  output logic [l2mlf_pkg::MASK_W-1:0]      out_port_mask,
  output logic [l2mlf_pkg::OPORT_W-1:0]     out_out_port,
  input  wire                               psel,
  input  wire                               penable,
  input  wire                               pwrite,
  input  wire [3:0]                         paddr,
  input  wire [31:0]                        pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  localparam int unsigned IDW  = $clog2(TABLE_DEPTH);
  localparam int unsigned CW   = $clog2(TABLE_DEPTH+1);
  localparam int unsigned SEG  = 8;
  localparam int unsigned LAT  = (TABLE_DEPTH + SEG - 1) / SEG;
  localparam int unsigned LTW  = $clog2(LAT + 2);
  localparam int unsigned PW   = $clog2(NUM_PORTS + 1);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_SRC   = 10'b0000000010,
    S_CHECK = 10'b0000000100,
    S_PURGE = 10'b0000001000,
    S_SCAN  = 10'b0000010000,
    S_EVICT = 10'b0000100000,
    S_INS   = 10'b0001000000,
    S_DST   = 10'b0010000000,
    S_RES   = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [l2mlf_pkg::LIMIT_W-1:0]   limit_r;
  logic [l2mlf_pkg::AGECFG_W-1:0]  aging_r;
  logic [l2mlf_pkg::PORTCFG_W-1:0] ports_r;
  logic [l2mlf_pkg::MAC_W-1:0]     src_r, dst_r;
  logic [2:0]                      port_r;
  logic [TIME_WIDTH-1:0]           now_r;
  logic [CW-1:0]                   count_r;
  logic [LTW-1:0]                  wait_r;
  logic                            out_valid_r;
  logic [l2mlf_pkg::ACTION_W-1:0]  act_r;
  logic [l2mlf_pkg::MASK_W-1:0]    mask_r;
  logic [2:0]                      oport_r;

  l2mlf_pkg::cmd_t                 cmd;
  logic [l2mlf_pkg::MAC_W-1:0]     key_mac;
  logic [IDW-1:0]                  sel_id;
  logic                            hit, hit_aged, old_found, free_found;
  logic [IDW-1:0]                  hit_id, old_id, free_id;
  logic [2:0]                      hit_port;
  logic [CW-1:0]                   aged_cnt, eff_limit;
  logic [TIME_WIDTH-1:0]           aging_lim;
  logic                            wr;
  logic [PW-1:0]                   nports;
  logic [NUM_PORTS-1:0]            fmask;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[3:2])
      l2mlf_pkg::REG_LIMIT: prdata = 32'(limit_r);
      l2mlf_pkg::REG_AGING: prdata = aging_r;
      l2mlf_pkg::REG_PORTS: prdata = 32'(ports_r);
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= '0;
      aging_r <= l2mlf_pkg::AGING_DEFAULT;
      ports_r <= 4'd8;
    end else if (wr) begin
      unique case (paddr[3:2])
        l2mlf_pkg::REG_LIMIT: limit_r <= pwdata[l2mlf_pkg::LIMIT_W-1:0];
        l2mlf_pkg::REG_AGING: aging_r <= pwdata;
        l2mlf_pkg::REG_PORTS: ports_r <= pwdata[l2mlf_pkg::PORTCFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (limit_r == '0 || 32'(limit_r) > TABLE_DEPTH)
      eff_limit = CW'(TABLE_DEPTH);
    else
      eff_limit = CW'(limit_r);
    aging_lim = TIME_WIDTH'((aging_r == '0) ? l2mlf_pkg::AGING_DEFAULT : aging_r);
    nports = (32'(ports_r) > NUM_PORTS) ? PW'(NUM_PORTS) : PW'(ports_r);
    for (int i = 0; i < NUM_PORTS; i++)
      fmask[i] = (PW'(i) < nports) && !(32'(port_r) == i);
  end

  l2mlf_row #(.DEPTH(TABLE_DEPTH), .TW(TIME_WIDTH), .SEG(SEG)) u_row (
    .clk, .rst_n, .cmd, .key_mac, .key_port(port_r), .key_now(now_r), .aging_lim,
    .sel_id, .hit, .hit_id, .hit_aged, .hit_port, .aged_cnt,
    .old_found, .old_id, .free_found, .free_id
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_action    = act_r;
  assign out_port_mask = mask_r;
  assign out_out_port  = oport_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = l2mlf_pkg::CMD_NONE;
    key_mac   = src_r;
    sel_id    = hit_id;
    unique case (state_r)
      S_IDLE:  if (in_valid && in_ready) state_nxt = S_SRC;
      S_SRC: begin
        if (hit) begin
          cmd       = l2mlf_pkg::CMD_REFR;
          state_nxt = S_DST;
        end else begin
          state_nxt = (count_r >= eff_limit) ? S_PURGE : S_SCAN;
        end
      end
      S_PURGE: begin
        cmd       = l2mlf_pkg::CMD_PURGE;
        state_nxt = S_SCAN;
      end
      S_SCAN:  ;
      S_CHECK: state_nxt = (count_r >= eff_limit && old_found) ? S_EVICT : S_INS;
      S_EVICT: begin
        cmd       = l2mlf_pkg::CMD_DROP;
        sel_id    = old_id;
        state_nxt = S_SCAN;
      end
      S_INS: begin
        if (free_found) cmd = l2mlf_pkg::CMD_INSERT;
        sel_id    = free_id;
        state_nxt = S_DST;
      end
      S_DST: begin
        key_mac = dst_r;
        if (!out_valid_r || out_ready) state_nxt = S_RES;
      end
      S_RES: begin
        key_mac = dst_r;
        if (dst_r != {l2mlf_pkg::MAC_W{1'b1}} && hit && hit_aged)
          cmd = l2mlf_pkg::CMD_DROP;
        state_nxt = S_OUT;
      end
      S_OUT:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
    if (state_r == S_SCAN && wait_r == LTW'(LAT)) state_nxt = S_CHECK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      wait_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wait_r  <= (state_r == S_SCAN) ? wait_r + LTW'(1) : '0;
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (state_r == S_OUT) out_valid_r <= 1'b1;
      unique case (state_r)
        S_PURGE: count_r <= count_r - aged_cnt;
        S_EVICT: count_r <= count_r - CW'(1);
        S_INS:   if (free_found) count_r <= count_r + CW'(1);
        S_RES:   if (cmd == l2mlf_pkg::CMD_DROP) count_r <= count_r - CW'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      src_r  <= in_src_mac;
      dst_r  <= in_dest_mac;
      port_r <= in_in_port;
      now_r  <= in_now;
    end
    if (state_r == S_RES) begin
      oport_r <= '0;
      if (dst_r == {l2mlf_pkg::MAC_W{1'b1}}) begin
        act_r  <= l2mlf_pkg::ACT_BCAST;
        mask_r <= l2mlf_pkg::MASK_W'(fmask);
      end else if (!hit || hit_aged) begin
        act_r  <= l2mlf_pkg::ACT_UNKNOWN;
        mask_r <= l2mlf_pkg::MASK_W'(fmask);
      end else if (hit_port == port_r) begin
        act_r  <= l2mlf_pkg::ACT_DISCARD;
        mask_r <= '0;
      end else begin
        act_r   <= l2mlf_pkg::ACT_UNICAST;
        oport_r <= hit_port;
        mask_r  <= l2mlf_pkg::MASK_W'(NUM_PORTS'(1) << hit_port);
      end
    end
  end

endmodule
`default_nettype wire

### dv/tb_l2_mac_learning_forwarder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_l2_mac_learning_forwarder
// Drives frame headers into the MAC learning forwarder, keeps a shadow of the
// learning table and registers, and checks each forwarding decision in order.
// ----------------------------------------------------------------------------
module tb_l2_mac_learning_forwarder;

  localparam int DEPTH    = 64;
  localparam int NPORTS   = 8;
  localparam int WDOG_MAX = 20000;
  localparam logic [47:0] BCAST_MAC = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    l2mlf_pkg::action_t action;
    logic [7:0]         port_mask;
    logic [2:0]         out_port;
  } decision_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [47:0] in_src_mac = '0;
  logic [47:0] in_dest_mac = '0;
  logic [2:0]  in_in_port = '0;
  logic [31:0] in_now = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_action;
  logic [7:0] out_port_mask;
  logic [2:0] out_out_port;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // shadow table and registers
  logic        tbl_valid [DEPTH];
  logic [47:0] tbl_mac   [DEPTH];
  logic [2:0]  tbl_port  [DEPTH];
  logic [31:0] tbl_time  [DEPTH];
  int          tbl_count;
  logic [6:0]  cfg_limit;
  logic [31:0] cfg_aging;
  logic [3:0]  cfg_ports;

  decision_t expected_q[$];
  int        errors = 0;
  int        wdog = 0;
  bit        rx_idle_en = 1'b1;
  bit        tx_idle_en = 1'b1;
  logic [31:0] clock_now = 32'd0;
  logic [47:0] mac_pool[16];

  l2_mac_learning_forwarder DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_src_mac(in_src_mac), .in_dest_mac(in_dest_mac),
    .in_in_port(in_in_port), .in_now(in_now),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_action(out_action), .out_port_mask(out_port_mask),
    .out_out_port(out_out_port),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [31:0] age_at(int i, logic [31:0] t);
    return t - tbl_time[i];
  endfunction

  function automatic bit is_stale(int i, logic [31:0] t);
    logic [31:0] lim;
    lim = (cfg_aging == 0) ? l2mlf_pkg::AGING_DEFAULT : cfg_aging;
    return age_at(i, t) >= lim;
  endfunction

  function automatic int lookup_mac(logic [47:0] mac);
    for (int i = 0; i < DEPTH; i++)
      if (tbl_valid[i] && tbl_mac[i] == mac) return i;
    return -1;
  endfunction

  function automatic void remove_slot(int i);
    if (tbl_valid[i]) begin
      tbl_valid[i] = 1'b0;
      tbl_count--;
    end
  endfunction

  function automatic logic [7:0] flood_ports(logic [2:0] port);
    int n;
    logic [8:0] m;
    n = (cfg_ports > NPORTS) ? NPORTS : cfg_ports;
    m = (9'd1 << n) - 9'd1;
    if (port < n) m[port] = 1'b0;
    return m[7:0];
  endfunction

  function automatic void learn_source(logic [47:0] mac, logic [2:0] port, logic [31:0] t);
    int hit, lim, best;
    logic [31:0] best_age, a;
    hit = lookup_mac(mac);
    if (hit >= 0) begin
      tbl_port[hit] = port;
      tbl_time[hit] = t;
      return;
    end
    lim = (cfg_limit == 0 || cfg_limit > DEPTH) ? DEPTH : cfg_limit;
    if (tbl_count >= lim) begin
      for (int i = 0; i < DEPTH; i++)
        if (tbl_valid[i] && is_stale(i, t)) remove_slot(i);
      while (tbl_count >= lim) begin
        best = -1;
        best_age = 0;
        for (int i = 0; i < DEPTH; i++) begin
          if (!tbl_valid[i]) continue;
          a = age_at(i, t);
          if (best < 0 || a > best_age || (a == best_age && tbl_mac[i] < tbl_mac[best])) begin
            best = i;
            best_age = a;
          end
        end
        if (best < 0) break;
        remove_slot(best);
      end
    end
    for (int i = 0; i < DEPTH; i++)
      if (!tbl_valid[i]) begin
        tbl_valid[i] = 1'b1;
        tbl_mac[i] = mac;
        tbl_port[i] = port;
        tbl_time[i] = t;
        tbl_count++;
        return;
      end
  endfunction

  function automatic decision_t forward_decision(logic [47:0] src, logic [47:0] dst,
                                                 logic [2:0] port, logic [31:0] t);
    decision_t d;
    int hit;
    learn_source(src, port, t);
    d = '{l2mlf_pkg::ACT_UNICAST, 8'd0, 3'd0};
    if (dst == BCAST_MAC) begin
      d.action = l2mlf_pkg::ACT_BCAST;
      d.port_mask = flood_ports(port);
    end else begin
      hit = lookup_mac(dst);
      if (hit >= 0 && is_stale(hit, t)) begin
        remove_slot(hit);
        hit = -1;
      end
      if (hit < 0) begin
        d.action = l2mlf_pkg::ACT_UNKNOWN;
        d.port_mask = flood_ports(port);
      end else if (tbl_port[hit] == port) begin
        d.action = l2mlf_pkg::ACT_DISCARD;
      end else begin
        d.out_port = tbl_port[hit];
        d.port_mask = 8'd1 << tbl_port[hit];
      end
    end
    return d;
  endfunction

  // result checker and receiver stalls
  always @(posedge clk) begin
    decision_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected transfer action=%0d mask=%h port=%0d", $time,
                 out_action, out_port_mask, out_out_port);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (out_action !== want.action) begin
          $display("%0t: action exp %0d got %0d", $time, want.action, out_action);
          errors++;
        end
        if (out_port_mask !== want.port_mask) begin
          $display("%0t: port_mask exp %h got %h", $time, want.port_mask, out_port_mask);
          errors++;
        end
        if (out_out_port !== want.out_port) begin
          $display("%0t: out_port exp %0d got %0d", $time, want.out_port, out_out_port);
          errors++;
        end
      end
    end
    out_ready <= rx_idle_en ? ($urandom_range(99) >= 22) : 1'b1;
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) wdog <= 0;
    else wdog <= wdog + 1;
    if (wdog >= WDOG_MAX) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic write_reg(l2mlf_pkg::reg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 4'(idx) << 2; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      l2mlf_pkg::REG_LIMIT: cfg_limit = val[6:0];
      l2mlf_pkg::REG_AGING: cfg_aging = val;
      default:              cfg_ports = val[3:0];
    endcase
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // valid stays up after the transfer; the next call replaces the header or lowers it, and drain() lowers it
  task automatic send_header(logic [47:0] src, logic [47:0] dst, logic [2:0] port,
                             logic [31:0] t);
    if (tx_idle_en)
      while ($urandom_range(99) < 22) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    in_valid <= 1'b1;
    in_src_mac <= src; in_dest_mac <= dst; in_in_port <= port; in_now <= t;
    expected_q.push_back(forward_decision(src, dst, port, t));
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic logic [47:0] rand_mac();
    return {16'($urandom), $urandom};
  endfunction

  task automatic test_directed();
    send_header(48'h0000_0000_0001, BCAST_MAC, 3'd0, 32'd0);
    send_header(48'hFFFF_FFFF_FFFE, 48'h0000_0000_0001, 3'd7, 32'd1);
    send_header(48'h0000_0000_0001, 48'hFFFF_FFFF_FFFE, 3'd0, 32'd2);
    send_header(48'h0000_0000_0002, 48'h0000_0000_0001, 3'd0, 32'd3);
    send_header(48'h0000_0000_0003, 48'h0000_0000_0000, 3'd5, 32'd4);
    send_header(48'h0000_0000_0000, 48'h0000_0000_0003, 3'd2, 32'd5);
    send_header(48'h0000_0000_0004, 48'h0000_0000_0001, 3'd1, 32'd20);
    send_header(48'h0000_0000_0005, 48'h0000_0000_0001, 3'd1, 32'd21);
    drain();
    write_reg(l2mlf_pkg::REG_PORTS, 32'd4);
    send_header(48'h0000_0000_0006, BCAST_MAC, 3'd6, 32'd22);
    send_header(48'h0000_0000_0007, BCAST_MAC, 3'd2, 32'd23);
    drain();
    write_reg(l2mlf_pkg::REG_PORTS, 32'd0);
    send_header(48'h0000_0000_0008, BCAST_MAC, 3'd1, 32'd24);
    drain();
    write_reg(l2mlf_pkg::REG_PORTS, 32'd15);
    write_reg(l2mlf_pkg::REG_AGING, 32'd0);
    send_header(48'h0000_0000_0009, 48'h0000_0000_0008, 3'd3, 32'd30);
    send_header(48'h0000_0000_000A, 48'h0000_0000_0008, 3'd3, 32'd40);
    drain();
    write_reg(l2mlf_pkg::REG_AGING, 32'hFFFF_FFFF);
    write_reg(l2mlf_pkg::REG_LIMIT, 32'd127);
    send_header(48'h0000_0000_000B, 48'h0000_0000_0009, 3'd4, 32'hFFFF_FFF0);
    send_header(48'h0000_0000_000C, 48'h0000_0000_000B, 3'd4, 32'h0000_0010);
    drain();
    write_reg(l2mlf_pkg::REG_LIMIT, 32'd2);
    send_header(48'h0000_0000_00F0, 48'h0000_0000_000B, 3'd1, 32'h0000_0020);
    send_header(48'h0000_0000_00F1, 48'h0000_0000_000C, 3'd1, 32'h0000_0020);
    send_header(48'h0000_0000_00F2, 48'h0000_0000_00F0, 3'd2, 32'h0000_0020);
    drain();
    clock_now = 32'h0000_0030;
  endtask

  task automatic test_random(int n_items, int pool_n, bit wrap_time);
    logic [47:0] src, dst;
    for (int k = 0; k < n_items; k++) begin
      src = ($urandom_range(9) == 0) ? rand_mac() : mac_pool[$urandom_range(pool_n - 1)];
      case ($urandom_range(9))
        0:       dst = BCAST_MAC;
        1:       dst = rand_mac();
        default: dst = mac_pool[$urandom_range(pool_n - 1)];
      endcase
      clock_now = clock_now + (wrap_time && $urandom_range(50) == 0 ? $urandom
                               : $urandom_range(3));
      send_header(src, dst, 3'($urandom), clock_now);
    end
    drain();
  endtask

  task automatic test_config_sweep();
    write_reg(l2mlf_pkg::REG_LIMIT, 32'd0);
    write_reg(l2mlf_pkg::REG_AGING, 32'd10);
    write_reg(l2mlf_pkg::REG_PORTS, 32'd8);
    test_random(400, 16, 1'b0);
    write_reg(l2mlf_pkg::REG_LIMIT, 32'd4);
    write_reg(l2mlf_pkg::REG_AGING, 32'd25);
    write_reg(l2mlf_pkg::REG_PORTS, 32'd5);
    test_random(400, 12, 1'b0);
    write_reg(l2mlf_pkg::REG_LIMIT, 32'd1);
    write_reg(l2mlf_pkg::REG_AGING, 32'd1);
    write_reg(l2mlf_pkg::REG_PORTS, 32'd1);
    test_random(200, 4, 1'b0);
    write_reg(l2mlf_pkg::REG_LIMIT, 32'd64);
    write_reg(l2mlf_pkg::REG_AGING, 32'd400);
    write_reg(l2mlf_pkg::REG_PORTS, 32'd8);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    test_random(300, 16, 1'b1);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    write_reg(l2mlf_pkg::REG_LIMIT, 32'd3);
    write_reg(l2mlf_pkg::REG_AGING, 32'd100);
    write_reg(l2mlf_pkg::REG_PORTS, 32'd3);
    test_random(600, 10, 1'b1);
  endtask

  initial begin
    for (int i = 0; i < DEPTH; i++) tbl_valid[i] = 1'b0;
    tbl_count = 0;
    cfg_limit = 7'd0;
    cfg_aging = l2mlf_pkg::AGING_DEFAULT;
    cfg_ports = 4'd8;
    for (int i = 0; i < 16; i++) mac_pool[i] = rand_mac();
    mac_pool[0] = 48'h0;
    mac_pool[1] = 48'hFFFF_FFFF_FFFE;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_config_sweep();
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
